// ===== rtl/core/marwh_pkg.sv =====
`default_nettype none
package marwh_pkg;

	localparam int unsigned WORD_W       = 64;
	localparam int unsigned HALF_W       = WORD_W / 2;
	localparam int unsigned ROT_W        = 6;
	localparam int unsigned FINAL_ROUNDS = 16;
	localparam int unsigned CNT_W        = $clog2(FINAL_ROUNDS + 2);
	localparam int unsigned REG_IDX_W    = 2;

	localparam logic [REG_IDX_W-1:0] REG_MULTIPLIER   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ADDEND       = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROTATE_RIGHT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_MLL,
		ST_MLH,
		ST_MHL,
		ST_ROT,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_ADD,
		OP_MLL,
		OP_MLH,
		OP_MHL,
		OP_ROT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic emit;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/mul_add_rotate_word_hash_core.sv =====
`default_nettype none
// Multiply-add-rotate hash over a stream of 64-bit words. Each input transaction carries a word
// in s_tdata, a has-word flag in s_tuser and an end-of-message mark in s_tlast; the digest of a
// message leaves on m_tdata after its last transaction, and the running value then restarts at
// zero. Every round runs on one shared 32x32 multiplier under a sequencer: add, three partial
// products and a rotate. A transaction with a word runs one round, an idle transaction (no word,
// not last) runs none, and a last transaction runs 16 + has_word rounds and then waits until the
// previous digest has been taken. No new transaction is accepted until the sequence is done.
// Program multiplier, addend and rotate_right only while the block is idle.
module mul_add_rotate_word_hash_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [marwh_pkg::WORD_W-1:0]      s_tdata,   // [63:0] word
	input  wire logic                              s_tuser,   // [0] has_word
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [marwh_pkg::WORD_W-1:0]      m_tdata,   // [63:0] digest
	input  wire logic                              wr_en,
	input  wire logic [marwh_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [marwh_pkg::WORD_W-1:0]      wr_data
);

	logic [marwh_pkg::WORD_W-1:0] multiplier_q;
	logic [marwh_pkg::WORD_W-1:0] addend_q;
	logic [marwh_pkg::ROT_W-1:0]  rotate_right_q;
	logic [marwh_pkg::WORD_W-1:0] digest_q;
	logic [marwh_pkg::WORD_W-1:0] value;
	logic                         m_tvalid_q;
	logic                         out_busy;
	marwh_pkg::ctrl_t             ctrl;

	assign out_busy = m_tvalid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multiplier_q   <= '0;
			addend_q       <= '0;
			rotate_right_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				marwh_pkg::REG_MULTIPLIER:   multiplier_q   <= wr_data;
				marwh_pkg::REG_ADDEND:       addend_q       <= wr_data;
				marwh_pkg::REG_ROTATE_RIGHT: rotate_right_q <= wr_data[marwh_pkg::ROT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	marwh_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.has_word (s_tuser),
		.last     (s_tlast),
		.out_busy (out_busy),
		.s_tready (s_tready),
		.ctrl     (ctrl)
	);

	marwh_round u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.word         (s_tdata),
		.multiplier   (multiplier_q),
		.addend       (addend_q),
		.rotate_right (rotate_right_q),
		.value        (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			digest_q <= value;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = digest_q;

endmodule
`default_nettype wire

// ===== rtl/core/marwh_round.sv =====
`default_nettype none
module marwh_round (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire marwh_pkg::ctrl_t              ctrl,
	input  wire logic [marwh_pkg::WORD_W-1:0]  word,
	input  wire logic [marwh_pkg::WORD_W-1:0]  multiplier,
	input  wire logic [marwh_pkg::WORD_W-1:0]  addend,
	input  wire logic [marwh_pkg::ROT_W-1:0]   rotate_right,
	output logic      [marwh_pkg::WORD_W-1:0]  value
);

	logic [marwh_pkg::WORD_W-1:0]   v_q;
	logic [marwh_pkg::WORD_W-1:0]   sum_q;
	logic [marwh_pkg::WORD_W-1:0]   acc_q;
	logic [marwh_pkg::HALF_W-1:0]   mul_a;
	logic [marwh_pkg::HALF_W-1:0]   mul_b;
	logic [marwh_pkg::WORD_W-1:0]   prod;
	logic [2*marwh_pkg::WORD_W-1:0] rot_wide;

	always_comb begin
		mul_a = (ctrl.op == marwh_pkg::OP_MHL) ? sum_q[marwh_pkg::WORD_W-1:marwh_pkg::HALF_W]
		                                       : sum_q[marwh_pkg::HALF_W-1:0];
		mul_b = (ctrl.op == marwh_pkg::OP_MLH) ? multiplier[marwh_pkg::WORD_W-1:marwh_pkg::HALF_W]
		                                       : multiplier[marwh_pkg::HALF_W-1:0];
		prod  = {{marwh_pkg::HALF_W{1'b0}}, mul_a} * {{marwh_pkg::HALF_W{1'b0}}, mul_b};
	end

	assign rot_wide = {acc_q, acc_q} >> rotate_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ctrl.emit) begin
			v_q <= '0;
		end else if (ctrl.op == marwh_pkg::OP_LOAD) begin
			v_q <= v_q ^ word;
		end else if (ctrl.op == marwh_pkg::OP_ROT) begin
			v_q <= rot_wide[marwh_pkg::WORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			marwh_pkg::OP_ADD: begin
				sum_q <= v_q + addend;
			end
			marwh_pkg::OP_MLL: begin
				acc_q <= prod;
			end
			marwh_pkg::OP_MLH, marwh_pkg::OP_MHL: begin
				acc_q[marwh_pkg::WORD_W-1:marwh_pkg::HALF_W] <=
					acc_q[marwh_pkg::WORD_W-1:marwh_pkg::HALF_W] + prod[marwh_pkg::HALF_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign value = v_q;

endmodule
`default_nettype wire

// ===== rtl/core/marwh_seq.sv =====
`default_nettype none
module marwh_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             has_word,
	input  wire logic             last,
	input  wire logic             out_busy,
	output logic                  s_tready,
	output marwh_pkg::ctrl_t      ctrl
);

	marwh_pkg::state_t            state_q;
	marwh_pkg::state_t            state_d;
	logic [marwh_pkg::CNT_W-1:0]  cnt_q;
	logic [marwh_pkg::CNT_W-1:0]  cnt_init;
	logic                         last_q;
	logic                         accept;

	assign accept   = s_tvalid && s_tready;
	assign cnt_init = marwh_pkg::CNT_W'(has_word)
	                + (last ? marwh_pkg::CNT_W'(marwh_pkg::FINAL_ROUNDS) : '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			marwh_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (cnt_init != '0) begin
						state_d = marwh_pkg::ST_ADD;
					end else if (last) begin
						state_d = marwh_pkg::ST_FIN;
					end
				end
			end
			marwh_pkg::ST_ADD: state_d = marwh_pkg::ST_MLL;
			marwh_pkg::ST_MLL: state_d = marwh_pkg::ST_MLH;
			marwh_pkg::ST_MLH: state_d = marwh_pkg::ST_MHL;
			marwh_pkg::ST_MHL: state_d = marwh_pkg::ST_ROT;
			marwh_pkg::ST_ROT: begin
				if (cnt_q != marwh_pkg::CNT_W'(1)) begin
					state_d = marwh_pkg::ST_ADD;
				end else if (last_q) begin
					state_d = marwh_pkg::ST_FIN;
				end else begin
					state_d = marwh_pkg::ST_IDLE;
				end
			end
			marwh_pkg::ST_FIN: begin
				if (!out_busy) begin
					state_d = marwh_pkg::ST_IDLE;
				end
			end
			default: state_d = marwh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ctrl.op   = marwh_pkg::OP_NONE;
		ctrl.emit = 1'b0;
		unique case (state_q)
			marwh_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && has_word) begin
					ctrl.op = marwh_pkg::OP_LOAD;
				end
			end
			marwh_pkg::ST_ADD: ctrl.op = marwh_pkg::OP_ADD;
			marwh_pkg::ST_MLL: ctrl.op = marwh_pkg::OP_MLL;
			marwh_pkg::ST_MLH: ctrl.op = marwh_pkg::OP_MLH;
			marwh_pkg::ST_MHL: ctrl.op = marwh_pkg::OP_MHL;
			marwh_pkg::ST_ROT: ctrl.op = marwh_pkg::OP_ROT;
			marwh_pkg::ST_FIN: ctrl.emit = !out_busy;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= marwh_pkg::ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q  <= cnt_init;
				last_q <= last;
			end else if (state_q == marwh_pkg::ST_ROT) begin
				cnt_q <= cnt_q - marwh_pkg::CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_emit_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> !out_busy)
		else $error("digest emitted while output register still held");

	a_fin_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == marwh_pkg::ST_FIN && !out_busy) |=> state_q == marwh_pkg::ST_IDLE)
		else $error("finish state not released after emit");

	a_add_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == marwh_pkg::ST_ADD) |-> cnt_q != '0)
		else $error("round started with no rounds pending");

	a_word_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == marwh_pkg::ST_ROT && cnt_q == marwh_pkg::CNT_W'(1) && !last_q)
		|=> state_q == marwh_pkg::ST_IDLE)
		else $error("non-final transaction did not return to idle");
`endif

endmodule
`default_nettype wire
